>>> rtl/dbcs_text_glyph_layout_defines.svh
// Assertion macros for the glyph layout block.
// Each expects clk and rst_n in the scope where it is used.
`ifndef DBCS_TEXT_GLYPH_LAYOUT_DEFINES_SVH
`define DBCS_TEXT_GLYPH_LAYOUT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define DBCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbcs assertion failed");
// Next-cycle implication.
`define DBCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbcs assertion failed");
`else
`define DBCS_ASSERT_IMPL(lbl, ante, cons)
`define DBCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/dbcs_pkg.sv
`default_nettype none
package dbcs_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int CFG_DATA_BITS      = 16;
    localparam int CFG_INDEX_BITS     = 3;

    // Character set constants
    localparam logic [7:0] GBK_LEAD_BASE  = 8'h81;
    localparam logic [7:0] GBK_ROW_SPAN   = 8'd190;
    localparam logic [7:0] GBK_TRAIL_BASE = 8'h40;
    localparam logic [7:0] GB_BASE        = 8'hA1;
    localparam logic [7:0] GB_ROW_SPAN    = 8'd94;
    localparam logic [7:0] FULLWIDTH_ROW  = 8'hA3;
    localparam logic [7:0] GBK_LEAD_MIN   = 8'h80;
    localparam logic [7:0] GB_LEAD_MIN    = 8'hA0;
    localparam logic [7:0] PRINT_LOW      = 8'h20;
    localparam logic [7:0] GBK_SPLIT      = 8'h5F;
    localparam logic [7:0] PRINT_HIGH     = 8'h7F;
    localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
    localparam logic [7:0] UPPER_HALF     = 8'h80;

    // Register reset values
    localparam logic        RST_CHARSET_MODE = 1'b0;
    localparam logic [5:0]  RST_FONT_WIDTH   = 6'd16;
    localparam logic [11:0] RST_LINE_WIDTH   = 12'd160;
    localparam logic [7:0]  RST_LINE_HEIGHT  = 8'd20;
    localparam logic [15:0] RST_GLYPH_COUNT  = 16'd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CHARSET_MODE,
        REG_FONT_WIDTH,
        REG_LINE_WIDTH,
        REG_LINE_HEIGHT,
        REG_GLYPH_COUNT
    } cfg_reg_t;

    typedef struct packed {
        logic        charset_mode;
        logic [5:0]  font_width;
        logic [11:0] line_width;
        logic [7:0]  line_height;
        logic [15:0] glyph_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        string_start;
        logic        string_end;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [4:0]  alpha_level;
    } text_item_t;

    typedef struct packed {
        logic [15:0] glyph_index;
        logic [15:0] glyph_x;
        logic [15:0] glyph_y;
        logic        glyph_valid;
        logic [4:0]  glyph_alpha;
    } glyph_item_t;

    // Per-byte control from the decoder to the cursor unit
    typedef struct packed {
        logic emit;
        logic advance_full;
        logic advance_half;
        logic newline;
        logic take_lead;
    } step_ctl_t;

endpackage
`default_nettype wire

>>> rtl/dbcs_ifs.sv
`default_nettype none
interface dbcs_text_if;
    logic        valid;
    logic        ready;
    logic [7:0]  text_byte;
    logic        string_start;
    logic        string_end;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [4:0]  alpha_level;

    modport source (
        output valid, text_byte, string_start, string_end, origin_x, origin_y, alpha_level,
        input  ready
    );
    modport sink (
        input  valid, text_byte, string_start, string_end, origin_x, origin_y, alpha_level,
        output ready
    );
endinterface

interface dbcs_glyph_if;
    logic        valid;
    logic        ready;
    logic [15:0] glyph_index;
    logic [15:0] glyph_x;
    logic [15:0] glyph_y;
    logic        glyph_valid;
    logic [4:0]  glyph_alpha;

    modport source (
        output valid, glyph_index, glyph_x, glyph_y, glyph_valid, glyph_alpha,
        input  ready
    );
    modport sink (
        input  valid, glyph_index, glyph_x, glyph_y, glyph_valid, glyph_alpha,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/dbcs_text_glyph_layout.sv
// A byte is captured in the input register when it is accepted, and its glyph is
//   written to the result register at the edge where the byte leaves it.
// Throughput: one byte per cycle; the cursor add/compare and the index multiply
//   sit between the input register and the result register. A blocked result
//   holds the waiting byte, glyph or not, and that stalls the input.
// Reset: rst_n (async, active low) empties both stages, clears the cursor state
//   and returns the configuration registers to their defaults.
`default_nettype none
`include "dbcs_text_glyph_layout_defines.svh"
module dbcs_text_glyph_layout
    import dbcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    dbcs_text_if.sink                      text_in,
    dbcs_glyph_if.source                   glyph_out
);

    // ---------------------------------------------------------------
    // Configuration registers, plain write port, no read-back
    // ---------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charset_mode <= RST_CHARSET_MODE;
            cfg_reg.font_width   <= RST_FONT_WIDTH;
            cfg_reg.line_width   <= RST_LINE_WIDTH;
            cfg_reg.line_height  <= RST_LINE_HEIGHT;
            cfg_reg.glyph_count  <= RST_GLYPH_COUNT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CHARSET_MODE: cfg_reg.charset_mode <= cfg_data[0];
                REG_FONT_WIDTH:   cfg_reg.font_width   <= cfg_data[5:0];
                REG_LINE_WIDTH:   cfg_reg.line_width   <= cfg_data[11:0];
                REG_LINE_HEIGHT:  cfg_reg.line_height  <= cfg_data[7:0];
                REG_GLYPH_COUNT:  cfg_reg.glyph_count  <= cfg_data[15:0];
                default:          ; // indexes past the list are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register: one byte waits here while the result register
    // is blocked; it is released as soon as the result slot frees up.
    // ---------------------------------------------------------------
    logic       s1_valid_reg, s1_valid_next;
    text_item_t s1_reg;
    logic       s1_fire;
    logic       in_take;

    logic        out_valid_reg, out_valid_next;
    glyph_item_t out_reg;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || glyph_out.ready);
    assign text_in.ready = !s1_valid_reg || s1_fire;
    assign in_take       = text_in.valid && text_in.ready;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg.text_byte    <= text_in.text_byte;
            s1_reg.string_start <= text_in.string_start;
            s1_reg.string_end   <= text_in.string_end;
            s1_reg.origin_x     <= text_in.origin_x;
            s1_reg.origin_y     <= text_in.origin_y;
            s1_reg.alpha_level  <= text_in.alpha_level;
        end
    end

    // ---------------------------------------------------------------
    // Decode and glyph index, then cursor/lead state. State moves
    // exactly once per byte, at the edge where the byte leaves s1.
    // ---------------------------------------------------------------
    step_ctl_t   ctl;
    logic [15:0] idx;
    logic        idx_ok;
    logic [7:0]  lead_byte;
    logic        lead_pending;
    logic [15:0] pos_x;
    logic [15:0] pos_y;

    dbcs_index u_index (
        .text_byte    (s1_reg.text_byte),
        .lead_byte    (lead_byte),
        .lead_pending (lead_pending),
        .string_end   (s1_reg.string_end),
        .cfg          (cfg_reg),
        .ctl          (ctl),
        .glyph_index  (idx),
        .glyph_valid  (idx_ok)
    );

    dbcs_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_fire),
        .string_start (s1_reg.string_start),
        .text_byte    (s1_reg.text_byte),
        .origin_x     (s1_reg.origin_x),
        .origin_y     (s1_reg.origin_y),
        .ctl          (ctl),
        .cfg          (cfg_reg),
        .lead_byte    (lead_byte),
        .lead_pending (lead_pending),
        .glyph_x      (pos_x),
        .glyph_y      (pos_y)
    );

    // ---------------------------------------------------------------
    // Result register: holds a glyph transaction until taken.
    // ---------------------------------------------------------------
    always_comb
    begin
        if (s1_fire)
            out_valid_next = ctl.emit;
        else if (glyph_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && ctl.emit)
        begin
            out_reg.glyph_index <= idx;
            out_reg.glyph_x     <= pos_x;
            out_reg.glyph_y     <= pos_y;
            out_reg.glyph_valid <= idx_ok;
            out_reg.glyph_alpha <= s1_reg.alpha_level;
        end
    end

    assign glyph_out.valid       = out_valid_reg;
    assign glyph_out.glyph_index = out_reg.glyph_index;
    assign glyph_out.glyph_x     = out_reg.glyph_x;
    assign glyph_out.glyph_y     = out_reg.glyph_y;
    assign glyph_out.glyph_valid = out_reg.glyph_valid;
    assign glyph_out.glyph_alpha = out_reg.glyph_alpha;

    // A blocked result with a byte waiting must hold off the input side.
    `DBCS_ASSERT_IMPL(a_stall_blocks_input, out_valid_reg && !glyph_out.ready && s1_valid_reg, !text_in.ready)
    // An in-range glyph never carries a negative index.
    `DBCS_ASSERT_IMPL(a_valid_index_nonneg, out_valid_reg && out_reg.glyph_valid, !out_reg.glyph_index[15])
    // A byte that leaves s1 with nothing behind it empties the stage.
    `DBCS_ASSERT_NEXT(a_fire_drains_s1, s1_fire && !in_take, !s1_valid_reg)

endmodule
`default_nettype wire

>>> rtl/dbcs_index.sv
`default_nettype none
module dbcs_index
    import dbcs_pkg::*;
(
    input  wire logic [7:0]  text_byte,
    input  wire logic [7:0]  lead_byte,
    input  wire logic        lead_pending,
    input  wire logic        string_end,
    input  wire cfg_t        cfg,
    output step_ctl_t        ctl,
    output logic [15:0]      glyph_index,
    output logic             glyph_valid
);

    localparam int IW = 18;

    logic              gb2312;
    logic              nonzero;
    logic              pair;
    logic              single;
    logic              printable;
    logic [7:0]        lead_min;
    logic [7:0]        h_sel;
    logic [7:0]        l_sel;
    logic [7:0]        l_gbk;
    logic signed [IW-1:0] h_s;
    logic signed [IW-1:0] l_s;
    logic signed [IW-1:0] idx_gbk;
    logic signed [IW-1:0] idx_gb;
    logic signed [IW-1:0] idx;

    always_comb
    begin
        gb2312   = cfg.charset_mode;
        nonzero  = (text_byte != '0);
        pair     = nonzero && lead_pending;
        lead_min = gb2312 ? GB_LEAD_MIN : GBK_LEAD_MIN;
        single   = nonzero && !lead_pending && (text_byte <= lead_min);

        if (gb2312)
            printable = (text_byte > PRINT_LOW) && (text_byte <= PRINT_HIGH);
        else
            printable = (text_byte > PRINT_LOW) && (text_byte < PRINT_HIGH);

        ctl.emit         = pair || (single && printable);
        ctl.advance_full = pair;
        ctl.advance_half = single;
        ctl.newline      = single && (text_byte == NEWLINE_BYTE);
        ctl.take_lead    = nonzero && !lead_pending && (text_byte > lead_min) && !string_end;

        // ASCII maps into the full-width row
        l_gbk = (text_byte < GBK_SPLIT) ? 8'(text_byte + PRINT_LOW)
                                        : 8'(text_byte + PRINT_LOW + 8'd1);
        h_sel = pair ? lead_byte : FULLWIDTH_ROW;
        l_sel = pair ? text_byte : (gb2312 ? 8'(UPPER_HALF + text_byte) : l_gbk);

        h_s = $signed({{(IW-8){1'b0}}, h_sel});
        l_s = $signed({{(IW-8){1'b0}}, l_sel});

        idx_gbk = (h_s - $signed({{(IW-8){1'b0}}, GBK_LEAD_BASE}))
                  * $signed({{(IW-8){1'b0}}, GBK_ROW_SPAN})
                  + (l_s - $signed({{(IW-8){1'b0}}, GBK_TRAIL_BASE}))
                  - $signed({{(IW-1){1'b0}}, l_sel[7]});
        idx_gb  = (h_s - $signed({{(IW-8){1'b0}}, GB_BASE}))
                  * $signed({{(IW-8){1'b0}}, GB_ROW_SPAN})
                  + (l_s - $signed({{(IW-8){1'b0}}, GB_BASE}));
        idx     = gb2312 ? idx_gb : idx_gbk;

        glyph_index = idx[15:0];
        glyph_valid = !idx[IW-1] && (idx[IW-2:0] < {{(IW-17){1'b0}}, cfg.glyph_count});
    end

endmodule
`default_nettype wire

>>> rtl/dbcs_cursor.sv
`default_nettype none
`include "dbcs_text_glyph_layout_defines.svh"
module dbcs_cursor
    import dbcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        string_start,
    input  wire logic [7:0]  text_byte,
    input  wire logic [15:0] origin_x,
    input  wire logic [15:0] origin_y,
    input  wire step_ctl_t   ctl,
    input  wire cfg_t        cfg,
    output logic [7:0]       lead_byte,
    output logic             lead_pending,
    output logic [15:0]      glyph_x,
    output logic [15:0]      glyph_y
);

    logic [COORD_BITS-1:0] cursor_reg, cursor_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] base_reg, base_next;
    logic [7:0]            lead_reg;
    logic                  pend_reg;

    logic [COORD_BITS-1:0] cur0;
    logic [COORD_BITS-1:0] xsum;
    logic [COORD_BITS-1:0] adv_base;
    logic [COORD_BITS-1:0] adv;
    logic [COORD_BITS-1:0] moved;
    logic                  wrap;

    always_comb
    begin
        cur0      = string_start ? '0 : cursor_reg;
        row_next  = string_start ? COORD_BITS'($signed(origin_y)) : row_reg;
        base_next = string_start ? COORD_BITS'($signed(origin_x)) : base_reg;
        xsum      = base_next + cur0;

        // newline parks the cursor at the line end so the advance wraps it
        adv_base = ctl.newline ? COORD_BITS'(cfg.line_width) : cur0;
        if (ctl.advance_full)
            adv = COORD_BITS'(cfg.font_width);
        else if (ctl.advance_half)
            adv = COORD_BITS'(cfg.font_width >> 1);
        else
            adv = '0;
        moved = adv_base + adv;
        wrap  = (ctl.advance_full || ctl.advance_half)
                && (moved >= COORD_BITS'(cfg.line_width));

        cursor_next = wrap ? '0 : moved;
        if (wrap)
            row_next = row_next + COORD_BITS'(cfg.line_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else if (step)
        begin
            cursor_reg <= cursor_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
            pend_reg   <= ctl.take_lead;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && ctl.take_lead)
            lead_reg <= text_byte;
    end

    assign lead_byte    = lead_reg;
    assign lead_pending = pend_reg && !string_start;
    // position of the glyph is taken before the advance
    assign glyph_x      = 16'(xsum);
    assign glyph_y      = 16'(string_start ? COORD_BITS'($signed(origin_y)) : row_reg);

    `DBCS_ASSERT_IMPL(a_lead_is_high, pend_reg, lead_reg[7])
    `DBCS_ASSERT_NEXT(a_pair_clears_lead, step && ctl.advance_full, !pend_reg)

endmodule
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dbcs_pkg::*;

    // Bounds for the run: the cycle limit covers the slowest legal run several
    // times over; the receiver hold-off is long enough to fill the pipeline.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 130;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    dbcs_text_if  text_ch ();
    dbcs_glyph_if glyph_ch ();

    dbcs_text_glyph_layout u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text_in   (text_ch),
        .glyph_out (glyph_ch)
    );

    // ------------------------------------------------------------------
    // Layout predictor state: our own copy of the registers and the cursor.
    // ------------------------------------------------------------------
    cfg_t        layout_cfg;
    logic [7:0]  held_lead;
    logic        lead_held;
    logic [15:0] cursor;
    logic [15:0] row_pos;
    logic [15:0] base_col;

    glyph_item_t pending_glyphs[$];   // expected glyphs, oldest first
    int          mismatches;
    int          bytes_sent;
    int          cycle_count;

    // Sender burst state
    int          burst_left;
    // Set by a test to make the receiver hold off for HOLD_CYCLES
    bit          hold_req;

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Runaway guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Advance the layout by one text byte. Returns 1 when a glyph is produced,
    // with the expected transaction in g.
    function automatic bit layout_byte(input text_item_t t, output glyph_item_t g);
        int         idx;
        int         lo;
        bit         gb;
        bit         emit_it;
        bit         full_step;
        bit         newline;
        logic [7:0] b;
        b         = t.text_byte;
        gb        = layout_cfg.charset_mode;
        emit_it   = 1'b0;
        full_step = 1'b0;
        newline   = 1'b0;
        idx       = 0;
        g         = '0;

        // String start reloads the origin and drops any held lead
        if (t.string_start)
        begin
            base_col  = t.origin_x;
            row_pos   = t.origin_y;
            cursor    = '0;
            lead_held = 1'b0;
        end

        // Terminator: nothing emitted, nothing advanced
        if (b == 8'h00)
        begin
            lead_held = 1'b0;
            return 1'b0;
        end

        if (lead_held)
        begin
            // Any nonzero byte completes the pair
            if (gb)
                idx = (int'(held_lead) - int'(GB_BASE)) * int'(GB_ROW_SPAN)
                      + (int'(b) - int'(GB_BASE));
            else
                idx = (int'(held_lead) - int'(GBK_LEAD_BASE)) * int'(GBK_ROW_SPAN)
                      + (int'(b) - int'(GBK_TRAIL_BASE)) - int'(b >> 7);
            lead_held = 1'b0;
            emit_it   = 1'b1;
            full_step = 1'b1;
        end
        else if (b > (gb ? GB_LEAD_MIN : GBK_LEAD_MIN))
        begin
            // Lead byte; on the last byte of a string it is dropped
            if (!t.string_end)
            begin
                held_lead = b;
                lead_held = 1'b1;
            end
            return 1'b0;
        end
        else if (gb)
        begin
            if (b > PRINT_LOW && b <= PRINT_HIGH)
            begin
                idx = (int'(FULLWIDTH_ROW) - int'(GB_BASE)) * int'(GB_ROW_SPAN)
                      + (int'(UPPER_HALF) + int'(b) - int'(GB_BASE));
                emit_it = 1'b1;
            end
            else if (b == NEWLINE_BYTE)
                newline = 1'b1;
        end
        else
        begin
            if (b > PRINT_LOW && b < PRINT_HIGH)
            begin
                // ASCII folds onto the full-width row, skipping the 0x7F trail
                lo  = (b < GBK_SPLIT) ? int'(b) + 32'h20 : int'(b) + 32'h21;
                idx = (int'(FULLWIDTH_ROW) - int'(GBK_LEAD_BASE)) * int'(GBK_ROW_SPAN)
                      + (lo - int'(GBK_TRAIL_BASE)) - (lo >> 7);
                emit_it = 1'b1;
            end
            else if (b == NEWLINE_BYTE)
                newline = 1'b1;
        end

        if (emit_it)
        begin
            g.glyph_index = 16'(idx);
            g.glyph_x     = base_col + cursor;
            g.glyph_y     = row_pos;
            g.glyph_valid = (idx >= 0) && (idx < int'(layout_cfg.glyph_count));
            g.glyph_alpha = t.alpha_level;
        end

        // Newline parks the cursor at the line end so the wrap below fires
        if (newline)
            cursor = 16'(layout_cfg.line_width);
        cursor = cursor + (full_step ? 16'(layout_cfg.font_width)
                                     : 16'(layout_cfg.font_width >> 1));
        if (cursor >= 16'(layout_cfg.line_width))
        begin
            cursor  = '0;
            row_pos = row_pos + 16'(layout_cfg.line_height);
        end
        return emit_it;
    endfunction

    function automatic cfg_t cfg_of(input logic m, input logic [5:0] fw,
                                    input logic [11:0] lw, input logic [7:0] lh,
                                    input logic [15:0] gc);
        cfg_t c;
        c.charset_mode = m;
        c.font_width   = fw;
        c.line_width   = lw;
        c.line_height  = lh;
        c.glyph_count  = gc;
        return c;
    endfunction

    // Byte with random origin and alpha; origin only matters on string start
    function automatic text_item_t text_item(input logic [7:0] b, input logic st,
                                             input logic en);
        text_item_t t;
        t.text_byte    = b;
        t.string_start = st;
        t.string_end   = en;
        t.origin_x     = 16'($urandom);
        t.origin_y     = 16'($urandom);
        t.alpha_level  = 5'($urandom);
        return t;
    endfunction

    // Offer one byte, with random gaps between bursts, and predict on accept.
    // valid stays high across back-to-back bytes; it only drops for a gap.
    task automatic send_byte(input text_item_t t);
        glyph_item_t g;
        int          gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= t.text_byte;
        text_ch.string_start <= t.string_start;
        text_ch.string_end   <= t.string_end;
        text_ch.origin_x     <= t.origin_x;
        text_ch.origin_y     <= t.origin_y;
        text_ch.alpha_level  <= t.alpha_level;
        do
            @(posedge clk);
        while (!text_ch.ready);
        bytes_sent++;
        if (layout_byte(t, g))
            pending_glyphs.push_back(g);
    endtask

    // Stop offering, let every expected glyph drain, then let non-emitting
    // bytes still in the pipeline settle.
    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program all five registers back to back while the block is idle
    task automatic apply_config(input cfg_t c);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CHARSET_MODE;
        cfg_data  <= CFG_DATA_BITS'(c.charset_mode);
        @(posedge clk);
        cfg_index <= REG_FONT_WIDTH;
        cfg_data  <= CFG_DATA_BITS'(c.font_width);
        @(posedge clk);
        cfg_index <= REG_LINE_WIDTH;
        cfg_data  <= CFG_DATA_BITS'(c.line_width);
        @(posedge clk);
        cfg_index <= REG_LINE_HEIGHT;
        cfg_data  <= CFG_DATA_BITS'(c.line_height);
        @(posedge clk);
        cfg_index <= REG_GLYPH_COUNT;
        cfg_data  <= CFG_DATA_BITS'(c.glyph_count);
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        layout_cfg  = c;
    endtask

    // One string of random tokens: mostly well-formed pairs and ASCII, with
    // newlines, control bytes, a lead cut off by a terminator and lone leads.
    task automatic send_string(input int tokens);
        logic [7:0] bytes_q[$];
        logic       gb;
        int         r;
        text_item_t t;
        gb = layout_cfg.charset_mode;
        for (int k = 0; k < tokens; k++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                bytes_q.push_back(gb ? 8'($urandom_range(161, 254))
                                     : 8'($urandom_range(129, 254)));
                if ($urandom_range(9) == 0)
                    bytes_q.push_back(8'($urandom_range(1, 255)));
                else
                    bytes_q.push_back(gb ? 8'($urandom_range(161, 254))
                                         : 8'($urandom_range(64, 254)));
            end
            else if (r < 75)
                bytes_q.push_back(8'($urandom_range(33, 126)));
            else if (r < 81)
                bytes_q.push_back(PRINT_LOW);
            else if (r < 88)
                bytes_q.push_back(NEWLINE_BYTE);
            else if (r < 94)
            begin
                if ($urandom_range(1) == 0)
                    bytes_q.push_back(8'($urandom_range(1, 31)));
                else
                    bytes_q.push_back(gb ? 8'($urandom_range(128, 160))
                                         : 8'($urandom_range(127, 128)));
            end
            else if (r < 97)
            begin
                // lead cut off by a terminator
                bytes_q.push_back(gb ? 8'($urandom_range(161, 255))
                                     : 8'($urandom_range(129, 255)));
                bytes_q.push_back(8'h00);
            end
            else
                bytes_q.push_back(gb ? 8'($urandom_range(161, 255))
                                     : 8'($urandom_range(129, 255)));
        end
        if ($urandom_range(3) == 0)
            bytes_q.push_back(8'h00);
        for (int k = 0; k < bytes_q.size(); k++)
        begin
            t = text_item(bytes_q[k], k == 0, k == bytes_q.size() - 1);
            send_byte(t);
        end
    endtask

    // Unstructured bytes with random framing flags
    task automatic send_noise(input int count);
        text_item_t t;
        for (int k = 0; k < count; k++)
        begin
            t = text_item(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
            send_byte(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults (GBK, glyph_count 0): ASCII fold at both sides of the
    // split, pair extremes, control bytes, newline, dropped leads.
    task automatic test_gbk_directed();
        text_item_t t;
        t = text_item(8'h00, 1'b1, 1'b0);
        t.origin_x = 16'h7FFF;
        t.origin_y = 16'h8000;
        send_byte(t);
        t = text_item(8'h21, 1'b1, 1'b0);
        t.origin_x    = 16'h8000;
        t.origin_y    = 16'h7FFF;
        t.alpha_level = 5'd0;
        send_byte(t);
        send_byte(text_item(8'h5E, 1'b0, 1'b0));
        send_byte(text_item(8'h5F, 1'b0, 1'b0));
        t = text_item(8'h7E, 1'b0, 1'b0);
        t.alpha_level = 5'd31;
        send_byte(t);
        send_byte(text_item(GBK_LEAD_BASE, 1'b0, 1'b0));
        send_byte(text_item(GBK_TRAIL_BASE, 1'b0, 1'b0));
        send_byte(text_item(8'hFF, 1'b0, 1'b0));
        send_byte(text_item(8'hFF, 1'b0, 1'b0));
        send_byte(text_item(PRINT_HIGH, 1'b0, 1'b0));   // control: half advance only
        send_byte(text_item(GBK_LEAD_MIN, 1'b0, 1'b0));
        send_byte(text_item(NEWLINE_BYTE, 1'b0, 1'b0));
        send_byte(text_item(GBK_LEAD_BASE, 1'b0, 1'b0)); // lead then terminator
        send_byte(text_item(8'h00, 1'b0, 1'b0));
        send_byte(text_item(8'h90, 1'b0, 1'b1));         // lead on string end
    endtask

    // GB2312 at the wide extremes, including a trail far below 0xA1
    task automatic test_gb2312_directed();
        apply_config(cfg_of(1'b1, 6'd32, 12'd4095, 8'd255, 16'hFFFF));
        send_byte(text_item(GB_BASE, 1'b1, 1'b0));
        send_byte(text_item(GB_BASE, 1'b0, 1'b0));
        send_byte(text_item(8'hFF, 1'b0, 1'b0));
        send_byte(text_item(8'hFF, 1'b0, 1'b0));
        send_byte(text_item(PRINT_HIGH, 1'b0, 1'b0));
        send_byte(text_item(GB_LEAD_MIN, 1'b0, 1'b0));
        send_byte(text_item(NEWLINE_BYTE, 1'b0, 1'b0));
        send_byte(text_item(GB_BASE, 1'b0, 1'b0));
        send_byte(text_item(8'h01, 1'b0, 1'b0));           // negative index
        send_byte(text_item(8'hFE, 1'b0, 1'b1));
    endtask

    // Zero font width and zero line width: no advance, wrap on every byte
    task automatic test_degenerate_registers();
        apply_config(cfg_of(1'b0, 6'd0, 12'd0, 8'd0, 16'd0));
        send_byte(text_item(8'h41, 1'b1, 1'b0));
        send_byte(text_item(NEWLINE_BYTE, 1'b0, 1'b0));
        send_byte(text_item(8'h42, 1'b0, 1'b1));
    endtask

    // Receiver holds off while the sender keeps offering glyph-producing
    // bytes, so the pipeline fills and ready drops; then a full drain.
    task automatic test_backpressure();
        apply_config(cfg_of(1'b0, 6'd8, 12'd200, 8'd10, 16'd30000));
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            send_byte(text_item(8'($urandom_range(33, 126)), k == 0, k == 39));
        wait_idle();
    endtask

    // Random strings and noise across several register settings
    task automatic test_random_layout();
        cfg_t phases[$];
        int   phase_start;
        phases.push_back(cfg_of(1'b0, 6'd32, 12'd4095, 8'd255, 16'hFFFF));
        phases.push_back(cfg_of(1'b1, 6'd1, 12'd1, 8'd0, 16'd1));
        phases.push_back(cfg_of(1'b0, 6'd16, 12'd160, 8'd20, 16'd8000));
        phases.push_back(cfg_of(1'b1, 6'd5, 12'd37, 8'd8, 16'd24131));
        phases.push_back(cfg_of(1'($urandom), 6'($urandom_range(1, 32)),
                                12'($urandom_range(1, 300)), 8'($urandom),
                                16'($urandom)));
        phases.push_back(cfg_of(1'($urandom), 6'($urandom_range(1, 32)),
                                12'($urandom_range(1, 4095)), 8'($urandom),
                                16'($urandom)));
        foreach (phases[p])
        begin
            apply_config(phases[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(99) < 85)
                    send_string($urandom_range(1, 12));
                else
                    send_noise($urandom_range(1, 6));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern, long hold-off on request, and the checker.
    // Outputs are sampled at the rising edge, before any update of this step.
    // ------------------------------------------------------------------
    initial
    begin
        int          hold_left;
        int          stall_run;
        int          stall_pct;
        glyph_item_t want;
        hold_left = 0;
        stall_run = 0;
        stall_pct = 0;
        glyph_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && glyph_ch.valid && glyph_ch.ready)
            begin
                if (pending_glyphs.size() == 0)
                begin
                    $error("unexpected glyph transaction: glyph_index %h", glyph_ch.glyph_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_glyphs.pop_front();
                    if (glyph_ch.glyph_index !== want.glyph_index)
                    begin
                        $error("glyph_index: expected %h, got %h",
                               want.glyph_index, glyph_ch.glyph_index);
                        mismatches++;
                    end
                    if (glyph_ch.glyph_x !== want.glyph_x)
                    begin
                        $error("glyph_x: expected %h, got %h", want.glyph_x, glyph_ch.glyph_x);
                        mismatches++;
                    end
                    if (glyph_ch.glyph_y !== want.glyph_y)
                    begin
                        $error("glyph_y: expected %h, got %h", want.glyph_y, glyph_ch.glyph_y);
                        mismatches++;
                    end
                    if (glyph_ch.glyph_valid !== want.glyph_valid)
                    begin
                        $error("glyph_valid: expected %b, got %b",
                               want.glyph_valid, glyph_ch.glyph_valid);
                        mismatches++;
                    end
                    if (glyph_ch.glyph_alpha !== want.glyph_alpha)
                    begin
                        $error("glyph_alpha: expected %h, got %h",
                               want.glyph_alpha, glyph_ch.glyph_alpha);
                        mismatches++;
                    end
                end
            end

            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                glyph_ch.ready <= 1'b0;
            end
            else
            begin
                // Runs of fixed stall density: none, light or heavy
                if (stall_run == 0)
                begin
                    stall_run = $urandom_range(10, 60);
                    case ($urandom_range(2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                end
                stall_run--;
                glyph_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_index            <= REG_CHARSET_MODE;
        cfg_data             <= '0;
        text_ch.valid        <= 1'b0;
        text_ch.text_byte    <= '0;
        text_ch.string_start <= 1'b0;
        text_ch.string_end   <= 1'b0;
        text_ch.origin_x     <= '0;
        text_ch.origin_y     <= '0;
        text_ch.alpha_level  <= '0;

        // Predictor matches the block's reset state
        layout_cfg  = cfg_of(RST_CHARSET_MODE, RST_FONT_WIDTH, RST_LINE_WIDTH,
                             RST_LINE_HEIGHT, RST_GLYPH_COUNT);
        held_lead   = '0;
        lead_held   = 1'b0;
        cursor      = '0;
        row_pos     = '0;
        base_col    = '0;
        mismatches  = 0;
        bytes_sent  = 0;
        cycle_count = 0;
        burst_left  = 0;
        hold_req    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gbk_directed();
        test_gb2312_directed();
        test_degenerate_registers();
        test_backpressure();
        test_random_layout();

        // Drain, then give the pipeline time to show any stray transaction
        text_ch.valid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending_glyphs.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dbcs_pkg.sv
rtl/dbcs_ifs.sv
rtl/dbcs_index.sv
rtl/dbcs_cursor.sv
rtl/dbcs_text_glyph_layout.sv
test/tb_top.sv
